>>> rtl/blkic_pkg.sv
`default_nettype none

package blkic_pkg;

  localparam int unsigned LEVEL_BITS = 16;
  // Signed working width for level arithmetic: room for level + step and a borrow
  localparam int unsigned LVL_SW = LEVEL_BITS + 3;
  localparam int unsigned IDLE_W = 16;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned SPAN_W = LEVEL_BITS + PCT_W;

  localparam logic [15:0] LEVEL_CAP = 16'((32'd1 << LEVEL_BITS) - 32'd1);

  localparam logic [15:0]       RST_MAX_LEVEL = 16'd2047;
  localparam logic [PCT_W-1:0]  RST_STEP_PCT  = 7'd10;
  localparam logic [PCT_W-1:0]  DEFAULT_STEP  = 7'd10;
  localparam logic [IDLE_W-1:0] RST_IDLE_SEC  = 16'd300;
  localparam logic [IDLE_W-1:0] IDLE_SAT      = 16'hFFFF;

  localparam logic [LEVEL_BITS-1:0] RST_LEVEL =
    (RST_MAX_LEVEL > LEVEL_CAP) ? LEVEL_CAP[LEVEL_BITS-1:0] : RST_MAX_LEVEL[LEVEL_BITS-1:0];

  // x/100 as (x * recip) >> shift; exact over the full input range of each use
  localparam int unsigned LO_SHIFT    = 23;
  localparam logic [16:0] LO_RECIP    = 17'd83887;
  localparam int unsigned DELTA_SHIFT = 30;
  localparam logic [23:0] DELTA_RECIP = 24'd10737419;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_KEY   = 2'd1,
    MODE_TOUCH = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KEY_OTHER    = 2'd0,
    KEY_VOL_UP   = 2'd1,
    KEY_VOL_DOWN = 2'd2,
    KEY_PWR      = 2'd3
  } key_e;

  typedef enum logic [1:0] {
    CFG_MAX_LEVEL    = 2'd0,
    CFG_STEP_PERCENT = 2'd1,
    CFG_IDLE_SECONDS = 2'd2
  } cfg_idx_e;

  // Limits derived from the configuration registers; a step above 100 percent
  // can exceed full scale, so delta carries one extra bit
  typedef struct packed {
    logic [LEVEL_BITS-1:0] hi;
    logic [LEVEL_BITS-1:0] lo;
    logic [LEVEL_BITS:0]   delta;
    logic [IDLE_W-1:0]     idle_lim;
  } lim_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] cur;
    logic                  off;
    logic [LEVEL_BITS-1:0] saved;
    logic [IDLE_W-1:0]     idle;
  } state_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  off;
    logic                  changed;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/backlight_key_idle_controller_core.sv
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: key_code, pressed; tuser: mode
// m_axis    out  m_axis_tvalid/tready        tdata: level, screen_off, level_changed
// cfg       in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not stalled and no limits are settling: an
// item waits in the input register, the update logic runs once and the result
// register takes the item when the output is free. A stalled output holds the
// result and the input register, which backs up into s_axis_tready.
// After reset and after each configuration write the input side holds off
// while the step size and minimum level are recomputed.
`default_nettype none

module backlight_key_idle_controller_core import blkic_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [1:0] key_code, [2] pressed
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [15:0] level, [16] screen_off, [17] level_changed

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  lim_t    lim;
  logic    cfg_busy;

  logic    in_vld_q;
  logic [1:0] in_mode_q, in_key_q;
  logic    in_press_q;

  state_t  st_q, st_d;
  result_t res;
  result_t out_q;
  logic    out_vld_q;

  logic    adv;
  logic    s_acc;

  blkic_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .busy_o      (cfg_busy),
    .lim_o       (lim)
  );

  blkic_step u_step (
    .st_i      (st_q),
    .lim_i     (lim),
    .mode_i    (in_mode_q),
    .key_i     (in_key_q),
    .pressed_i (in_press_q),
    .st_o      (st_d),
    .res_o     (res)
  );

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !cfg_busy && (!in_vld_q || adv);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_mode_q  <= s_axis_tuser;
      in_key_q   <= s_axis_tdata[1:0];
      in_press_q <= s_axis_tdata[2];
    end
  end

  // Commit state as the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.cur   <= RST_LEVEL;
      st_q.off   <= 1'b0;
      st_q.saved <= '0;
      st_q.idle  <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_q.changed, out_q.off, 16'(out_q.level)};

  // An off screen always drives level zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.off |-> (st_q.cur == '0))
    else $error("screen off with nonzero level");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[16]) |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("result shows screen off with nonzero level");

  // Turning off is always a panel write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && st_d.off && !st_q.off) |-> res.changed)
    else $error("turn-off without level write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_busy |-> !s_axis_tready)
    else $error("input accepted while limits settle");

  // A visible-level move must be flagged as a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (st_d.cur != st_q.cur)) |-> res.changed)
    else $error("level moved without write flag");

endmodule

`default_nettype wire

>>> rtl/blkic_cfg.sv
`default_nettype none

module blkic_cfg import blkic_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             cfg_ready_o,
  output logic             busy_o,
  output lim_t             lim_o
);

  logic [15:0]       max_q;
  logic [PCT_W-1:0]  step_q;
  logic [IDLE_W-1:0] idle_q;
  logic [1:0]        busy_q, busy_d;

  logic [LEVEL_BITS-1:0]    eff_max;
  logic [PCT_W-1:0]         pct;
  logic [LEVEL_BITS-1:0]    hi1_q;
  logic [SPAN_W-1:0]        span_q;
  logic [LEVEL_BITS+16:0]   lo_prod_q;
  logic [SPAN_W+23:0]       delta_prod;
  logic [LEVEL_BITS-1:0]    lo_raw;
  lim_t                     lim_q;

  logic wr;

  assign cfg_ready_o = 1'b1;
  assign wr = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= RST_MAX_LEVEL;
      step_q <= RST_STEP_PCT;
      idle_q <= RST_IDLE_SEC;
    end else if (wr) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_LEVEL:    max_q  <= cfg_data_i;
        CFG_STEP_PERCENT: step_q <= cfg_data_i[PCT_W-1:0];
        CFG_IDLE_SECONDS: idle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Derived limits settle through the first-stage registers and lim_q after a write; hold the input side until then
  always_comb begin
    busy_d = busy_q;
    if (wr) begin
      busy_d = 2'd2;
    end else if (busy_q != 2'd0) begin
      busy_d = busy_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 2'd2;
    end else begin
      busy_q <= busy_d;
    end
  end

  assign busy_o = (busy_q != 2'd0);

  assign eff_max = (max_q > LEVEL_CAP) ? LEVEL_CAP[LEVEL_BITS-1:0] : max_q[LEVEL_BITS-1:0];
  assign pct     = (step_q == '0) ? DEFAULT_STEP : step_q;

  always_ff @(posedge clk_i) begin
    hi1_q     <= eff_max;
    span_q    <= SPAN_W'(eff_max) * SPAN_W'(pct);
    lo_prod_q <= (LEVEL_BITS+17)'(eff_max) * (LEVEL_BITS+17)'(LO_RECIP);
  end

  assign delta_prod = (SPAN_W+24)'(span_q) * (SPAN_W+24)'(DELTA_RECIP);
  assign lo_raw     = lo_prod_q[LO_SHIFT +: LEVEL_BITS];

  always_ff @(posedge clk_i) begin
    lim_q.hi       <= hi1_q;
    lim_q.lo       <= (lo_raw == '0) ? LEVEL_BITS'(1) : lo_raw;
    lim_q.delta    <= delta_prod[DELTA_SHIFT +: LEVEL_BITS+1];
    lim_q.idle_lim <= idle_q;
  end

  assign lim_o = lim_q;

endmodule

`default_nettype wire

>>> rtl/blkic_step.sv
`default_nettype none

module blkic_step import blkic_pkg::*; (
  input  wire state_t     st_i,
  input  wire lim_t       lim_i,
  input  wire logic [1:0] mode_i,
  input  wire logic [1:0] key_i,
  input  wire logic       pressed_i,
  output state_t          st_o,
  output result_t         res_o
);

  function automatic logic [LEVEL_BITS-1:0] clamp_lvl(
    input logic signed [LVL_SW-1:0] want,
    input logic [LEVEL_BITS-1:0]    hi,
    input logic [LEVEL_BITS-1:0]    lo
  );
    logic signed [LVL_SW-1:0] w;
    w = want;
    if (w > signed'(LVL_SW'(hi))) w = signed'(LVL_SW'(hi));
    if (w < signed'(LVL_SW'(lo))) w = signed'(LVL_SW'(lo));
    return w[LEVEL_BITS-1:0];
  endfunction

  logic [LEVEL_BITS-1:0]    on_lvl;
  logic [LEVEL_BITS-1:0]    base;
  logic                     base_chg;
  logic signed [LVL_SW-1:0] base_s, delta_s;
  logic [LEVEL_BITS-1:0]    up_lvl, dn_lvl, vol_lvl;
  logic [IDLE_W-1:0]        idle_inc;
  logic                     changed;

  // Restore path: saved level reapplied under the current limits
  assign on_lvl   = clamp_lvl(signed'(LVL_SW'(st_i.saved)), lim_i.hi, lim_i.lo);
  assign base     = st_i.off ? on_lvl : st_i.cur;
  assign base_chg = st_i.off && (on_lvl != st_i.cur);
  assign base_s   = signed'(LVL_SW'(base));
  assign delta_s  = signed'(LVL_SW'(lim_i.delta));
  assign up_lvl   = clamp_lvl(base_s + delta_s, lim_i.hi, lim_i.lo);
  assign dn_lvl   = clamp_lvl(base_s - delta_s, lim_i.hi, lim_i.lo);
  assign vol_lvl  = (key_e'(key_i) == KEY_VOL_UP) ? up_lvl : dn_lvl;
  assign idle_inc = (st_i.idle == IDLE_SAT) ? st_i.idle : st_i.idle + IDLE_W'(1);

  always_comb begin
    st_o    = st_i;
    changed = 1'b0;
    case (mode_e'(mode_i))
      MODE_TICK: begin
        st_o.idle = idle_inc;
        if ((lim_i.idle_lim != '0) && !st_i.off && (idle_inc >= lim_i.idle_lim)) begin
          st_o.saved = st_i.cur;
          st_o.off   = 1'b1;
          st_o.cur   = '0;
          changed    = 1'b1;
        end
      end
      MODE_KEY: begin
        st_o.idle = '0;
        if (pressed_i) begin
          case (key_e'(key_i))
            KEY_VOL_UP, KEY_VOL_DOWN: begin
              st_o.off = 1'b0;
              st_o.cur = vol_lvl;
              changed  = base_chg || (vol_lvl != base);
            end
            KEY_PWR: begin
              if (st_i.off) begin
                st_o.off = 1'b0;
                st_o.cur = on_lvl;
                changed  = base_chg;
              end else begin
                st_o.saved = st_i.cur;
                st_o.off   = 1'b1;
                st_o.cur   = '0;
                changed    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      MODE_TOUCH: begin
        st_o.idle = '0;
        if (st_i.off) begin
          st_o.off = 1'b0;
          st_o.cur = on_lvl;
          changed  = base_chg;
        end
      end
      default: ;
    endcase
  end

  assign res_o.level   = st_o.cur;
  assign res_o.off     = st_o.off;
  assign res_o.changed = changed;

endmodule

`default_nettype wire
